/* design/bfa_pkg.sv */
package bfa_pkg;

   localparam int LEVELS_DEF       = 7;
   localparam int TOTAL_FRAMES_DEF = 4096;
   localparam int FRAME_W          = 20;
   localparam int COUNT_W          = 7;
   localparam int TOP_W            = 7;
   localparam int WORD_W           = 64;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OOM = 2'd1,
      ST_BAD = 2'd2
   } status_type;

   typedef enum logic {
      CSR_BASE_FRAME = 1'b0,
      CSR_TOP_BLOCKS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRD,
      S_SCHK,
      S_SPLIT,
      S_BRD,
      S_BWR,
      S_DONE
   } state_type;

   // Commands from the sequencer to the bitmap store.
   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } map_cmd_type;

   // Bits in the bitmap of one level.
   function automatic int lbits(int total, int lvl);
      return total >> lvl;
   endfunction

   // 64-bit words that hold one level.
   function automatic int lwords(int total, int lvl);
      return ((total >> lvl) + 63) >> 6;
   endfunction

   // First word of a level in the store.
   function automatic int lbase(int total, int lvl);
      int s;
      s = 0;
      for (int i = 0; i < lvl; i++) s = s + lwords(total, i);
      return s;
   endfunction

endpackage

/* design/buddy_frame_allocator_unit.sv */
// Buddy page-frame allocator with one free bitmap per block size.
// The request channel (req_) carries one word per command: req_tuser selects
// allocate (0) or free (1), req_tdata holds the frame count and the frame to
// release. The response channel (rsp_) returns one word per command with a
// status and the page number of an allocated block.
// A small sequencer drives one bitmap store through a single read/modify/write
// port, so one command is handled at a time and req_tready is high only when
// the block is idle. A free reads and rewrites one bitmap word, and a rejected
// command goes straight to the response. An allocation reads one 64-bit word
// at a time while it searches upward from the smallest fitting level, then
// runs the split, read and write states on each level of the split walk down
// from the found block. On a fresh map, where only the top level is free, a
// one-frame request scans all 127 words.
// Reset idles the sequencer, zeroes the base, sets top_blocks to 64 and marks
// every bitmap row as not yet written, so the map reads as top level free and
// lower levels empty at once, with no clearing pass. Writing top_blocks
// restarts the map the same way. If the receiver stalls, the result is held in
// the response register, and the sequencer waits before presenting the next.
module buddy_frame_allocator_unit #(
   parameter int LEVELS       = bfa_pkg::LEVELS_DEF,
   parameter int TOTAL_FRAMES = bfa_pkg::TOTAL_FRAMES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // frame_count[6:0], free_frame[26:7], zero pad
   input  logic        req_tuser,   // func: 0 allocate, 1 free
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], alloc_frame[21:2], zero pad
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [19:0] csr_wdata
);
   import bfa_pkg::*;

   localparam int DEPTH  = lbase(TOTAL_FRAMES, LEVELS);
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW     = $clog2(LEVELS + 1);
   localparam int IDX_W  = $clog2(TOTAL_FRAMES) + 1;
   localparam int WW     = IDX_W - 6;
   localparam int CMP_W  = (LEVELS + 1 > COUNT_W) ? LEVELS + 1 : COUNT_W;

   state_type          state_ff, state_in;
   logic [FRAME_W-1:0] base_ff;
   logic [TOP_W-1:0]   top_ff;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [LW-1:0]      lvl_ff, lvl_in;
   logic [WW-1:0]      w_ff, w_in;
   logic [LW-1:0]      nl_ff, nl_in;
   logic [IDX_W-1:0]   nb_ff, nb_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [LW-1:0]      wl_ff, wl_in;
   logic [IDX_W-1:0]   wi_ff, wi_in;
   logic               wv_ff, wv_in;
   logic               ret_ff, ret_in;
   status_type         st_ff, st_in;
   logic [FRAME_W-1:0] res_ff, res_in;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_data_ff;

   logic [AW-1:0]      lbase_tab [LEVELS];
   logic [WW-1:0]      last_tab  [LEVELS];
   logic [FRAME_W:0]   lbits_tab [LEVELS];

   map_cmd_type        cmd;
   logic [AW-1:0]      maddr;
   logic [WORD_W-1:0]  wdata, rdata;

   logic [COUNT_W-1:0] q_n;
   logic [FRAME_W-1:0] q_frame;
   logic [LW-1:0]      q_lvl;
   logic               q_bad;
   logic [FRAME_W-1:0] q_off;
   logic [FRAME_W-1:0] q_idx;
   logic [5:0]         tz;
   logic [CMP_W-1:0]   cap, half;
   logic               accept, load_rsp;

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         lbase_tab[l] = AW'(lbase(TOTAL_FRAMES, l));
         last_tab[l]  = WW'(lwords(TOTAL_FRAMES, l) - 1);
         lbits_tab[l] = (FRAME_W + 1)'(lbits(TOTAL_FRAMES, l));
      end
   end

   assign q_n     = req_tdata[COUNT_W-1:0];
   assign q_frame = req_tdata[COUNT_W +: FRAME_W];
   assign accept  = req_tvalid && req_tready;

   // Smallest level whose block holds the count; LEVELS when none does.
   always_comb begin
      q_lvl = LW'(LEVELS);
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if ((CMP_W'(1) << l) >= CMP_W'(q_n)) q_lvl = LW'(l);
      end
      q_bad = (q_n == '0) || (q_lvl == LW'(LEVELS));
      q_off = q_frame - base_ff;
      q_idx = q_off >> q_lvl;
   end

   // Lowest set bit of the word just read.
   always_comb begin
      tz = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (rdata[j]) tz = 6'(j);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= '0;
         top_ff   <= TOP_W'(64);
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_BASE_FRAME: base_ff <= csr_wdata;
               CSR_TOP_BLOCKS: top_ff  <= csr_wdata[TOP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      lvl_ff <= lvl_in;
      w_ff   <= w_in;
      nl_ff  <= nl_in;
      nb_ff  <= nb_in;
      rem_ff <= rem_in;
      wl_ff  <= wl_in;
      wi_ff  <= wi_in;
      wv_ff  <= wv_in;
      ret_ff <= ret_in;
      st_ff  <= st_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      lvl_in   = lvl_ff;
      w_in     = w_ff;
      nl_in    = nl_ff;
      nb_in    = nb_ff;
      rem_in   = rem_ff;
      wl_in    = wl_ff;
      wi_in    = wi_ff;
      wv_in    = wv_ff;
      ret_in   = ret_ff;
      st_in    = st_ff;
      res_in   = res_ff;
      cmd      = '0;
      maddr    = lbase_tab[wl_ff] + AW'(wi_ff[IDX_W-1:6]);
      wdata    = rdata;
      load_rsp = 1'b0;
      req_tready = 1'b0;
      cap      = CMP_W'(1) << nl_ff;
      half     = cap >> 1;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               n_in   = q_n;
               lvl_in = q_lvl;
               w_in   = '0;
               res_in = '0;
               if (!req_tuser) begin
                  st_in    = ST_OOM;
                  state_in = q_bad ? S_DONE : S_SRD;
               end else if (q_bad || (q_frame < base_ff)
                            || ({1'b0, q_idx} >= lbits_tab[q_lvl[$clog2(LEVELS)-1:0]])) begin
                  st_in    = ST_BAD;
                  state_in = S_DONE;
               end else begin
                  st_in    = ST_OK;
                  wl_in    = q_lvl;
                  wi_in    = q_idx[IDX_W-1:0];
                  wv_in    = 1'b1;
                  ret_in   = 1'b0;
                  state_in = S_BRD;
               end
            end
         end
         S_SRD: begin
            maddr    = lbase_tab[lvl_ff] + AW'(w_ff);
            cmd.rd   = 1'b1;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            maddr = lbase_tab[lvl_ff] + AW'(w_ff);
            if (rdata != '0) begin
               wdata    = rdata & ~(WORD_W'(1) << tz);
               cmd.wr   = 1'b1;
               nl_in    = lvl_ff;
               nb_in    = {w_ff, tz};
               rem_in   = n_ff;
               st_in    = ST_OK;
               res_in   = base_ff + (FRAME_W'({w_ff, tz}) << lvl_ff);
               state_in = S_SPLIT;
            end else if (w_ff != last_tab[lvl_ff]) begin
               w_in     = w_ff + WW'(1);
               state_in = S_SRD;
            end else if (lvl_ff != LW'(LEVELS - 1)) begin
               lvl_in   = lvl_ff + LW'(1);
               w_in     = '0;
               state_in = S_SRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SPLIT: begin
            state_in = S_BRD;
            if (CMP_W'(rem_ff) == cap) begin
               // Remaining count fills this block exactly: it is used.
               wl_in  = nl_ff;
               wi_in  = nb_ff;
               wv_in  = 1'b0;
               ret_in = 1'b0;
            end else if (CMP_W'(rem_ff) <= half) begin
               // Right half stays unused and becomes free; go left.
               wl_in  = nl_ff - LW'(1);
               wi_in  = {nb_ff[IDX_W-2:0], 1'b1};
               wv_in  = 1'b1;
               ret_in = 1'b1;
               nl_in  = nl_ff - LW'(1);
               nb_in  = {nb_ff[IDX_W-2:0], 1'b0};
            end else begin
               // Left half is fully used; the remainder goes right.
               wl_in  = nl_ff - LW'(1);
               wi_in  = {nb_ff[IDX_W-2:0], 1'b0};
               wv_in  = 1'b0;
               ret_in = 1'b1;
               nl_in  = nl_ff - LW'(1);
               nb_in  = {nb_ff[IDX_W-2:0], 1'b1};
               rem_in = rem_ff - COUNT_W'(half);
            end
         end
         S_BRD: begin
            cmd.rd   = 1'b1;
            state_in = S_BWR;
         end
         S_BWR: begin
            cmd.wr = 1'b1;
            if (wv_ff) wdata = rdata | (WORD_W'(1) << wi_ff[5:0]);
            else       wdata = rdata & ~(WORD_W'(1) << wi_ff[5:0]);
            state_in = ret_ff ? S_SPLIT : S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      cmd.clr = csr_we && (csr_index_type'(csr_addr) == CSR_TOP_BLOCKS);
   end

   bfa_map #(
      .LEVELS       (LEVELS),
      .TOTAL_FRAMES (TOTAL_FRAMES),
      .DEPTH        (DEPTH),
      .AW           (AW)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .addr       (maddr),
      .wdata      (wdata),
      .top_blocks (top_ff),
      .rdata      (rdata)
   );

   // Response register: holds one word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) rsp_data_ff <= {2'b00, res_ff, st_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted command always leaves the idle state.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after a command");

   // A result is never loaded over one that the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten");

   // A delivered status is always one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("undefined status code");

   // A store write addresses a real row.
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> maddr < AW'(DEPTH))
      else $error("bitmap write out of range");

endmodule

/* design/bfa_map.sv */
module bfa_map #(
   parameter int LEVELS       = bfa_pkg::LEVELS_DEF,
   parameter int TOTAL_FRAMES = bfa_pkg::TOTAL_FRAMES_DEF,
   parameter int DEPTH        = 127,
   parameter int AW           = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bfa_pkg::map_cmd_type       cmd,
   input  logic [AW-1:0]              addr,
   input  logic [bfa_pkg::WORD_W-1:0] wdata,
   input  logic [bfa_pkg::TOP_W-1:0]  top_blocks,
   output logic [bfa_pkg::WORD_W-1:0] rdata
);
   import bfa_pkg::*;

   localparam int TOP_BASE = lbase(TOTAL_FRAMES, LEVELS - 1);
   localparam int TOP_BITS = lbits(TOTAL_FRAMES, LEVELS - 1);
   localparam int CW       = AW + 7;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [WORD_W-1:0] mem_q_ff;
   logic              vld_q_ff;
   logic [AW-1:0]     raddr_ff;
   logic [AW-1:0]     row_off;
   logic [WORD_W-1:0] fill;

   // A row never written reads as its reset value.
   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         valid_ff <= '0;
      end else if (cmd.wr) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd) begin
         mem_q_ff <= mem[addr];
         vld_q_ff <= valid_ff[addr];
         raddr_ff <= addr;
      end
   end

   // Only the top level starts with set bits, the first top_blocks of them.
   always_comb begin
      row_off = raddr_ff - AW'(TOP_BASE);
      for (int j = 0; j < WORD_W; j++) begin
         fill[j] = (raddr_ff >= AW'(TOP_BASE))
                   && (((CW'(row_off) << 6) + CW'(j)) < CW'(top_blocks))
                   && (((CW'(row_off) << 6) + CW'(j)) < CW'(TOP_BITS));
      end
      rdata = vld_q_ff ? mem_q_ff : fill;
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

// Testbench for the buddy page-frame allocator.
// One process feeds command words on the req_ channel, a second process
// drains result words on the rsp_ channel, and a monitor compares every
// result word with the oldest entry of the queue of predicted results. The
// prediction comes from a bit-level copy of the free bitmaps kept here.
module tb;
   import bfa_pkg::*;

   localparam bit FN_ALLOC = 1'b0;
   localparam bit FN_FREE  = 1'b1;
   localparam int NLEV     = 7;
   localparam int NFRAMES  = 4096;
   localparam int PHASE_WORDS = 260;

   // One predicted result word.
   typedef struct {
      status_type status;
      logic [19:0] frame;
   } alloc_result_type;

   // One row of the directed table. When known is set, the typed result is
   // the one that must come back; otherwise the predictor decides.
   typedef struct {
      bit          fn;
      logic [6:0]  count;
      logic [19:0] frame;
      bit          known;
      status_type  status;
      logic [19:0] result;
   } cmd_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // frame_count[6:0], free_frame[26:7], zero pad
   logic        req_tuser;   // func: 0 allocate, 1 free
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // status[1:0], alloc_frame[21:2], zero pad
   logic        csr_we;
   logic        csr_addr;
   logic [19:0] csr_wdata;

   // Mirror of the allocator state.
   bit   [NFRAMES-1:0] free_bits [NLEV];
   logic [19:0]        base_mirror;
   logic [6:0]         top_mirror;

   alloc_result_type pending_results[$];
   // Blocks handed out and not yet returned, used to build well-formed frees.
   logic [19:0]   held_frame[$];
   logic [6:0]    held_count[$];

   int  mismatches   = 0;
   int  results_seen = 0;
   bit  send_calm;
   bit  drain_calm   = 1'b0;

   buddy_frame_allocator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A generous ceiling: even the slowest search over every level, with both
   // sides idling as long as they may, stays far below this.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Reset of the mirror: the whole map is cleared and the first top_blocks
   // bits of the 64-frame level are marked free, saturated to its 64 bits.
   function automatic void refill_map();
      int n;
      for (int l = 0; l < NLEV; l++) free_bits[l] = '0;
      n = (top_mirror > 64) ? 64 : top_mirror;
      for (int i = 0; i < n; i++) free_bits[NLEV-1][i] = 1'b1;
   endfunction

   // Works out the result of one command and updates the mirror.
   function automatic alloc_result_type predict_command(input bit fn,
                                                        input logic [6:0] count,
                                                        input logic [19:0] frame);
      alloc_result_type r;
      int   lvl, l, k, blk, found;
      logic [19:0] offs;
      r.status = ST_OOM;
      r.frame  = '0;
      lvl = 0;
      while (lvl < NLEV && (1 << lvl) < count) lvl++;
      if (fn == FN_ALLOC) begin
         if (count != 0 && lvl < NLEV) begin
            found = -1;
            for (int s = lvl; s < NLEV && found < 0; s++) begin
               for (int i = 0; i < (NFRAMES >> s); i++) begin
                  if (free_bits[s][i]) begin
                     found = i;
                     l = s;
                     break;
                  end
               end
            end
            if (found >= 0) begin
               free_bits[l][found] = 1'b0;
               r.status = ST_OK;
               r.frame  = 20'(base_mirror + 20'(found << l));
               // Walk the split down: a request that fits in the lower half
               // leaves the upper half free, otherwise the lower half is used
               // up whole and the walk continues in the upper half.
               k   = count;
               blk = found;
               forever begin
                  if (k == (1 << l)) begin
                     free_bits[l][blk] = 1'b0;
                     break;
                  end
                  if (k <= (1 << (l - 1))) begin
                     free_bits[l-1][2*blk+1] = 1'b1;
                     blk = 2 * blk;
                  end else begin
                     free_bits[l-1][2*blk] = 1'b0;
                     k   = k - (1 << (l - 1));
                     blk = 2 * blk + 1;
                  end
                  l--;
               end
            end
         end
      end else begin
         r.status = ST_BAD;
         if (count != 0 && lvl < NLEV && frame >= base_mirror) begin
            offs = frame - base_mirror;
            if ((offs >> lvl) < (NFRAMES >> lvl)) begin
               free_bits[lvl][offs >> lvl] = 1'b1;
               r.status = ST_OK;
            end
         end
      end
      return r;
   endfunction

   function automatic int send_gap();
      return send_calm ? 0 : $urandom_range(0, 16);
   endfunction

   // Offers one command word and waits until it is taken. The valid stays
   // high into the next word when no gap is drawn.
   task automatic offer_command(input cmd_row_type row);
      int gap;
      alloc_result_type r;
      gap = send_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.fn;
      req_tdata  <= {5'b0, row.frame, row.count};
      // Outputs settle between edges, so the ready seen at the falling edge
      // is the one the next rising edge samples.
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      r = predict_command(row.fn, row.count, row.frame);
      if (row.known) begin
         if (r.status != row.status || r.frame != row.result)
            $display("[%0t] note: typed result differs from prediction", $realtime);
         r.status = row.status;
         r.frame  = row.result;
      end
      if (row.fn == FN_ALLOC && r.status == ST_OK) begin
         held_frame.push_back(r.frame);
         held_count.push_back(row.count);
      end
      pending_results.push_back(r);
   endtask

   // Registers are only written with nothing in flight.
   task automatic write_reg(input csr_index_type idx, input logic [19:0] value);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BASE_FRAME) begin
         base_mirror = value;
      end else begin
         top_mirror = value[6:0];
         refill_map();
         held_frame.delete();
         held_count.delete();
      end
   endtask

   // One random command. Most are allocations of small blocks and returns of
   // blocks that were handed out, so the map gets split deep and refilled;
   // the rest are odd counts, stray frames and frees far outside the map.
   function automatic cmd_row_type random_command();
      cmd_row_type c;
      int pick, sel;
      c.known  = 1'b0;
      c.status = ST_OK;
      c.result = '0;
      c.frame  = 20'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         c.fn    = FN_ALLOC;
         c.count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 64))
                                               : 7'($urandom_range(1, 8));
      end else if (pick < 80 && held_frame.size() > 0) begin
         sel     = $urandom_range(0, held_frame.size() - 1);
         c.fn    = FN_FREE;
         c.count = held_count[sel];
         // Any frame inside the block returns the whole block.
         c.frame = held_frame[sel] + 20'($urandom_range(0, held_count[sel] - 1));
         held_frame.delete(sel);
         held_count.delete(sel);
      end else if (pick < 90) begin
         c.fn    = FN_ALLOC;
         c.count = 7'($urandom_range(0, 127));
      end else begin
         c.fn    = FN_FREE;
         c.count = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 1) == 1) c.frame = base_mirror + 20'($urandom_range(0, 4200));
      end
      return c;
   endfunction

   // Result side: draws a stall per word, with calm stretches and one long
   // hold that lets the allocator back up into its request channel.
   initial begin : drain
      int gap;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         if (results_seen == 150) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < 600; n++) @(posedge clock);
         end else begin
            if (($urandom_range(0, 31)) == 0) drain_calm = ~drain_calm;
            gap = drain_calm ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
      end
   end

   // Compares each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected word %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] != want.status)
               report($sformatf("status %0d, wanted %0d", rsp_tdata[1:0], want.status));
            if (rsp_tdata[21:2] != want.frame)
               report($sformatf("frame %h, wanted %h", rsp_tdata[21:2], want.frame));
            if (rsp_tdata[23:22] != 2'b0)
               report("nonzero pad bits");
         end
      end
   end

   // Directed table: the typed rows follow from the map right after reset,
   // with base 0 and all 64 top blocks free.
   cmd_row_type directed[] = '{
      '{FN_ALLOC, 7'd64,  20'd0,       1'b1, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd1,   20'd0,       1'b1, ST_OK,  20'd64},
      '{FN_ALLOC, 7'd0,   20'd0,       1'b1, ST_OOM, 20'd0},
      '{FN_ALLOC, 7'd127, 20'd0,       1'b1, ST_OOM, 20'd0},
      '{FN_ALLOC, 7'd65,  20'd0,       1'b1, ST_OOM, 20'd0},
      '{FN_FREE,  7'd0,   20'd5,       1'b1, ST_BAD, 20'd0},
      '{FN_FREE,  7'd127, 20'd5,       1'b1, ST_BAD, 20'd0},
      '{FN_FREE,  7'd65,  20'd5,       1'b1, ST_BAD, 20'd0},
      '{FN_FREE,  7'd1,   20'hFFFFF,   1'b1, ST_BAD, 20'd0},
      '{FN_FREE,  7'd64,  20'd4095,    1'b1, ST_OK,  20'd0},
      '{FN_FREE,  7'd64,  20'd4096,    1'b1, ST_BAD, 20'd0},
      '{FN_FREE,  7'd64,  20'd0,       1'b1, ST_OK,  20'd0},
      '{FN_FREE,  7'd64,  20'd0,       1'b1, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd3,   20'd0,       1'b0, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd2,   20'd0,       1'b0, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd5,   20'd0,       1'b0, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd33,  20'd0,       1'b0, ST_OK,  20'd0},
      '{FN_FREE,  7'd5,   20'd71,      1'b0, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd1,   20'd0,       1'b0, ST_OK,  20'd0},
      '{FN_FREE,  7'd1,   20'd4095,    1'b0, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd1,   20'd0,       1'b0, ST_OK,  20'd0},
      '{FN_ALLOC, 7'd63,  20'd0,       1'b0, ST_OK,  20'd0}
   };

   // Settings walked by the random phases: extremes of both registers,
   // a base that makes allocated page numbers wrap, and an empty map.
   logic [19:0] phase_base[5] = '{20'd0, 20'hFFFFF, 20'hFF000, 20'd4096, 20'h5A5A5};
   logic [6:0]  phase_top[5]  = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd17};

   initial begin : stimulus
      send_calm    = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = CSR_BASE_FRAME;
      csr_wdata    = '0;
      base_mirror  = '0;
      top_mirror   = 7'd64;
      refill_map();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) offer_command(directed[i]);

      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_BASE_FRAME, phase_base[p]);
         write_reg(CSR_TOP_BLOCKS, {13'b0, phase_top[p]});
         // On the empty map, allocations fail until stray frees return blocks.
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ((n % 40) == 0) send_calm = ($urandom_range(0, 2) == 0);
            offer_command(random_command());
         end
      end
      req_tvalid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
